// File: design/ple_pkg.sv
`default_nettype none

package ple_pkg;

  // Field widths fixed by the item format.
  localparam int PosW  = 5;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// File: design/positional_list_engine.sv
`default_nettype none

// Positional list engine. The block holds an ordered list of up to CAPACITY
// signed 32-bit values in a single synchronous RAM, together with an entry
// count, and runs one command per input item: insert at a 1-based position,
// delete at a position (returning the removed value), locate the first entry
// equal to a value, or read the entry at a position. Every item produces
// exactly one result item carrying a status, the element, the found index and
// the new list length. A bad position, or an insert into a full list, returns
// status 1 and leaves the list untouched. The list is walked through the
// single read port of the RAM, one entry per cycle, and each entry that moves
// is written back in the cycle after it is read. Items are handled one at a time,
// but the next item is taken while the previous result still waits in the
// output register; a command that finishes while that result is still held
// by a stalled output waits in its final cycle until the register is free.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              command_i,
  input  wire logic [PosW-1:0]         position_i,
  input  wire logic signed [DataW-1:0] value_i,

  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         status_o,
  output logic signed [DataW-1:0]      element_o,
  output logic [PosW-1:0]              found_index_o,
  output logic [PosW-1:0]              length_o
);

  // Address width of the RAM, width of the entry count, and a comparison
  // width that holds both a position and the count plus one.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > PosW) ? CW : PosW) + 1;

  // Control state.
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q;
  logic            rv_q;        // read data for rv_addr_q arrives this cycle
  logic            first_q;     // next read issued is the first of the walk
  logic            rv_first_q;  // read data now arriving is the first of the walk
  logic            hit_q;       // locate has already seen a match
  logic            out_valid_q;

  // Command payload and walk registers.
  cmd_e            cmd_q;
  logic [DataW-1:0] val_q;
  logic            err_q;
  logic [AW-1:0]   put_addr_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   last_q;
  logic            up_q;
  logic [AW-1:0]   rv_addr_q;
  logic [DataW-1:0] elem_q;
  logic [CW-1:0]   found_q;

  // Output register.
  logic            status_q;
  logic [DataW-1:0] element_q;
  logic [PosW-1:0] found_out_q;
  logic [PosW-1:0] length_q;

  // RAM port signals.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic            ram_re;
  logic [DataW-1:0] ram_rdata;

  ple_ram #(
    .Width (DataW),
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Handshake terms.
  logic in_acc;
  logic out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Decode of an incoming command against the current count. All comparisons
  // are done at a width that cannot overflow for any position or capacity.
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] cnt_m1;
  logic          pos_zero;
  logic          ins_err;
  logic          acc_err;
  logic          ins_append;

  always_comb begin
    pos_ext    = PW'(position_i);
    cnt_ext    = PW'(count_q);
    pos_m1     = pos_ext - PW'(1);
    cnt_m1     = cnt_ext - PW'(1);
    pos_zero   = (position_i == '0);
    ins_err    = pos_zero || (pos_ext > cnt_ext + PW'(1)) || (cnt_ext >= PW'(CAPACITY));
    acc_err    = pos_zero || (pos_ext > cnt_ext);
    ins_append = (pos_ext == cnt_ext + PW'(1));
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (ins_err) begin
                state_d = ST_FINISH;
              end else if (ins_append) begin
                state_d = ST_PUT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_LOCATE: begin
              state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
            end
            CMD_DELETE, CMD_READ: begin
              state_d = acc_err ? ST_FINISH : ST_SCAN;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (addr_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = (cmd_q == CMD_INSERT) ? ST_PUT : ST_FINISH;
      end
      ST_PUT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM control. Reads are issued while walking; the data returned in the
  // following cycle is written back one place up (insert) or one place down (delete).
  // The first entry read by a delete is the removed value and is not moved.
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = rv_addr_q;
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_SCAN, ST_DRAIN: begin
        ram_re = (state_q == ST_SCAN);
        if (rv_q) begin
          if (cmd_q == CMD_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = rv_addr_q + AW'(1);
          end else if (cmd_q == CMD_DELETE && !rv_first_q) begin
            ram_we    = 1'b1;
            ram_waddr = rv_addr_q - AW'(1);
          end
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_addr_q;
        ram_wdata = val_q;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Count after the current command completes.
  logic [CW-1:0] count_new;
  logic [PW-1:0] count_new_ext;
  logic [PW-1:0] found_ext;

  always_comb begin
    count_new = count_q;
    if (!err_q) begin
      if (cmd_q == CMD_INSERT) begin
        count_new = count_q + CW'(1);
      end else if (cmd_q == CMD_DELETE) begin
        count_new = count_q - CW'(1);
      end
    end
    count_new_ext = PW'(count_new);
    found_ext     = PW'(found_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rv_q        <= 1'b0;
      first_q     <= 1'b0;
      rv_first_q  <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        first_q <= 1'b1;
        hit_q   <= 1'b0;
        rv_q    <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        rv_q       <= 1'b1;
        rv_first_q <= first_q;
        first_q    <= 1'b0;
      end else if (state_q == ST_DRAIN) begin
        rv_q <= 1'b0;
      end
      if (rv_q && cmd_q == CMD_LOCATE && !hit_q && ram_rdata == val_q) begin
        hit_q <= 1'b1;
      end
      if (state_q == ST_FINISH && out_free) begin
        count_q     <= count_new;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= cmd_e'(command_i);
      val_q      <= value_i;
      put_addr_q <= pos_m1[AW-1:0];
      elem_q     <= '0;
      found_q    <= '0;
      unique case (cmd_e'(command_i))
        CMD_INSERT: begin
          err_q  <= ins_err;
          addr_q <= cnt_m1[AW-1:0];
          last_q <= pos_m1[AW-1:0];
          up_q   <= 1'b0;
        end
        CMD_DELETE: begin
          err_q  <= acc_err;
          addr_q <= pos_m1[AW-1:0];
          last_q <= cnt_m1[AW-1:0];
          up_q   <= 1'b1;
        end
        CMD_LOCATE: begin
          err_q  <= 1'b0;
          addr_q <= '0;
          last_q <= cnt_m1[AW-1:0];
          up_q   <= 1'b1;
        end
        CMD_READ: begin
          err_q  <= acc_err;
          addr_q <= pos_m1[AW-1:0];
          last_q <= pos_m1[AW-1:0];
          up_q   <= 1'b1;
        end
        default: begin
          err_q <= 1'b0;
          up_q  <= 1'b1;
        end
      endcase
    end

    if (state_q == ST_SCAN) begin
      rv_addr_q <= addr_q;
      addr_q    <= up_q ? addr_q + AW'(1) : addr_q - AW'(1);
    end

    // Handle the entry whose read data arrives in this cycle.
    if (rv_q) begin
      if (cmd_q == CMD_READ || (cmd_q == CMD_DELETE && rv_first_q)) begin
        elem_q <= ram_rdata;
      end
      if (cmd_q == CMD_LOCATE && !hit_q && ram_rdata == val_q) begin
        found_q <= CW'(rv_addr_q) + CW'(1);
      end
    end

    if (state_q == ST_FINISH && out_free) begin
      status_q    <= err_q;
      element_q   <= elem_q;
      found_out_q <= found_ext[PosW-1:0];
      length_q    <= count_new_ext[PosW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign element_o     = element_q;
  assign found_index_o = found_out_q;
  assign length_o      = length_q;

endmodule

`default_nettype wire

// File: design/ple_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ple_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
